// ===== src/shdlc_pkg.sv =====
// Shared constants, codes and result types of the frame receiver.
package shdlc_pkg;

    // Framing and escape bytes
    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_CODE_FLAG = 8'h5E;
    localparam logic [7:0] ESC_CODE_ESC  = 8'h5D;
    localparam logic [7:0] ESC_CODE_XON  = 8'h31;
    localparam logic [7:0] ESC_CODE_XOFF = 8'h33;
    localparam logic [7:0] XON_BYTE      = 8'h11;
    localparam logic [7:0] XOFF_BYTE     = 8'h13;

    // Body byte counter saturates here
    localparam logic [8:0] POS_MAX = 9'd511;

    // Verdict codes
    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_LEN_ERR  = 2'd1;
    localparam logic [1:0] VERDICT_CSUM_ERR = 2'd2;
    localparam logic [1:0] VERDICT_DEV_ERR  = 2'd3;

    // Result queue geometry (depth is a power of two so pointers wrap)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Output stream data width: payload, verdict, state, padded to bytes
    localparam int M_DATA_W = 24;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] payload_byte;
        logic [1:0] verdict;
        logic [7:0] device_state;
    } t_result;

    // One queue entry: all results caused by one received byte
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

endpackage

// ===== src/shdlc_frame_receiver_unit.sv =====
// Top level of the byte-stuffed frame receiver.
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) carries raw serial bytes, one per beat.
//  - Master stream (m_tvalid/m_tready/m_tdata/m_tlast) carries results: a payload
//    byte per beat while m_tlast is low, and one verdict beat with m_tlast high at
//    the closing flag of each frame.
//  - i_cfg_wr_en/i_cfg_wr_data set the expected payload length; write it only
//    while the block is idle.
//  - One byte is accepted every cycle while the queue is not full. A byte that yields
//    two results (an unrecognized escape) takes two output beats; a four-entry queue
//    between the decoder and the output register absorbs this.
//  - A byte's results are written into the queue on its acceptance edge and then
//    loaded into the output register in turn; a second result follows the first.
//  - When m_tready stays low the output register holds, the queue fills, and
//    s_tready drops once it is full.
//  - Reset clears the frame state, the queue and the output valid flag, and sets the
//    expected payload length to zero.
module shdlc_frame_receiver_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [7:0]                      i_cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [9:8] verdict, [17:10] device_state, [23:18] zero
    output logic [shdlc_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast    // frame_end
);
    import shdlc_pkg::*;

    logic   push;
    t_entry push_entry;
    logic   full;
    logic   pop;
    logic   empty;
    t_entry head;

    shdlc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_full        (full),
        .o_push        (push),
        .o_push_entry  (push_entry)
    );

    shdlc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_head       (head)
    );

    shdlc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

// ===== src/shdlc_front.sv =====
// Front end: accepts raw bytes, unstuffs, tracks the frame and builds result entries.
module shdlc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic               i_full,
    output logic               o_push,
    output shdlc_pkg::t_entry  o_push_entry
);
    import shdlc_pkg::*;

    typedef struct packed {
        logic       in_frame;
        logic       esc;
        logic [8:0] pos;
        logic [7:0] sum;
        logic [7:0] chk;
        logic [7:0] st;
        logic       ovr;
    } t_fstate;

    // Account one unstuffed body byte
    function automatic t_fstate take_body(t_fstate s, logic [7:0] b, logic [7:0] plen);
        t_fstate    t;
        logic [8:0] lim;
        t   = s;
        lim = 9'd4 + {1'b0, plen};
        if (s.pos < lim) begin
            t.sum = s.sum + b;
            if (s.pos == 9'd2) begin
                t.st = b;
            end
        end else if (s.pos == lim) begin
            t.chk = b;
        end else begin
            t.ovr = 1'b1;
        end
        if (s.pos != POS_MAX) begin
            t.pos = s.pos + 9'd1;
        end
        return t;
    endfunction

    // A body byte at this position is payload
    function automatic logic is_payload(logic [8:0] pos, logic [7:0] plen);
        logic [8:0] lim;
        lim = 9'd4 + {1'b0, plen};
        return (pos < lim) && (pos >= 9'd4);
    endfunction

    function automatic t_result payload_res(logic [7:0] b);
        t_result r;
        r              = '0;
        r.payload_byte = b;
        return r;
    endfunction

    function automatic t_result verdict_res(t_fstate s, logic [7:0] plen);
        t_result    r;
        logic [8:0] want;
        r         = '0;
        want      = 9'd5 + {1'b0, plen};
        r.frame_end    = 1'b1;
        r.device_state = s.st;
        if (s.ovr || (s.pos != want)) begin
            r.verdict = VERDICT_LEN_ERR;
        end else if (~s.sum != s.chk) begin
            r.verdict = VERDICT_CSUM_ERR;
        end else if (s.st != 8'd0) begin
            r.verdict = VERDICT_DEV_ERR;
        end else begin
            r.verdict = VERDICT_OK;
        end
        return r;
    endfunction

    logic [7:0] r_plen;
    t_fstate    r_st;
    t_fstate    n_st;
    t_result    res0;
    t_result    res1;
    logic [1:0] cnt;
    logic [7:0] body;
    logic       go_on;
    logic       accept;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;

    // Hold the expected payload length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= 8'd0;
        end else if (i_cfg_wr_en) begin
            r_plen <= i_cfg_wr_data;
        end
    end

    // Decode one byte: at most two results
    always_comb begin
        n_st  = r_st;
        res0  = '0;
        res1  = '0;
        cnt   = 2'd0;
        body  = ESC_BYTE;
        go_on = 1'b1;
        if (!r_st.in_frame) begin
            if (i_s_tdata == FLAG_BYTE) begin
                n_st          = '0;
                n_st.in_frame = 1'b1;
            end
        end else begin
            // Finish a pending escape first
            if (r_st.esc) begin
                n_st.esc = 1'b0;
                case (i_s_tdata)
                    ESC_CODE_FLAG: begin body = FLAG_BYTE; go_on = 1'b0; end
                    ESC_CODE_ESC:  begin body = ESC_BYTE;  go_on = 1'b0; end
                    ESC_CODE_XON:  begin body = XON_BYTE;  go_on = 1'b0; end
                    ESC_CODE_XOFF: begin body = XOFF_BYTE; go_on = 1'b0; end
                    default:       begin body = ESC_BYTE;  go_on = 1'b1; end
                endcase
                if (is_payload(n_st.pos, r_plen)) begin
                    res0 = payload_res(body);
                    cnt  = 2'd1;
                end
                n_st = take_body(n_st, body, r_plen);
            end
            // Then the byte on its own, unless consumed by the escape
            if (go_on) begin
                if (i_s_tdata == FLAG_BYTE) begin
                    if (cnt == 2'd0) begin
                        res0 = verdict_res(n_st, r_plen);
                        cnt  = 2'd1;
                    end else begin
                        res1 = verdict_res(n_st, r_plen);
                        cnt  = 2'd2;
                    end
                    n_st.in_frame = 1'b0;
                end else if (i_s_tdata == ESC_BYTE) begin
                    n_st.esc = 1'b1;
                end else begin
                    if (is_payload(n_st.pos, r_plen)) begin
                        if (cnt == 2'd0) begin
                            res0 = payload_res(i_s_tdata);
                            cnt  = 2'd1;
                        end else begin
                            res1 = payload_res(i_s_tdata);
                            cnt  = 2'd2;
                        end
                    end
                    n_st = take_body(n_st, i_s_tdata, r_plen);
                end
            end
        end
    end

    // Advance frame state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    assign o_push              = accept && (cnt != 2'd0);
    assign o_push_entry.two    = cnt[1];
    assign o_push_entry.first  = res0;
    assign o_push_entry.second = res1;

endmodule

// ===== src/shdlc_queue.sv =====
// Short result queue between front end and output stage.
module shdlc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  shdlc_pkg::t_entry  i_push_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output shdlc_pkg::t_entry  o_head
);
    import shdlc_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/shdlc_back.sv =====
// Back end: unpacks queue entries into single result beats on an output register.
module shdlc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  shdlc_pkg::t_entry               i_head,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [shdlc_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);
    import shdlc_pkg::*;

    logic    r_valid;
    t_result r_out;
    logic    r_sub;
    logic    load;
    t_result pick;

    assign load  = !r_valid || i_m_tready;
    assign pick  = r_sub ? i_head.second : i_head.first;
    assign o_pop = load && !i_empty && (r_sub || !i_head.two);

    // Refill the output register when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_sub <= o_pop ? 1'b0 : 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_out <= pick;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_out.frame_end;
    assign o_m_tdata  = {6'd0, r_out.device_state, r_out.verdict, r_out.payload_byte};

endmodule

// ===== sim/tb_shdlc_frame_receiver_unit.sv =====
// Self-checking testbench for the byte-stuffed frame receiver: random frames, scoreboard.
module tb_shdlc_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import shdlc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int RUNAWAY_BYTES = 520;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [7:0]          i_cfg_wr_data = 8'h00;
    logic                s_tvalid      = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata       = 8'h00;   // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready      = 1'b0;
    // [7:0] payload_byte, [9:8] verdict, [17:10] device_state, [23:18] zero
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;                 // frame_end

    // Raw bytes waiting to be sent, and results the receiver still owes
    logic [7:0] rx_stream[$];
    t_result    expected_results[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    bit  hold_kick      = 1'b0;
    bit  in_fire        = 1'b0;
    int  cycle_count    = 0;
    int  result_count   = 0;
    int  mismatch_count = 0;

    // Shadow of the frame decoder
    logic       fr_open    = 1'b0;
    logic       fr_esc     = 1'b0;
    logic       fr_overrun = 1'b0;
    logic [8:0] fr_pos     = '0;
    logic [7:0] fr_sum     = 8'h00;
    logic [7:0] fr_check   = 8'h00;
    logic [7:0] fr_state   = 8'h00;
    logic [7:0] payload_len = 8'h00;

    shdlc_frame_receiver_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic t_result make_result(logic fe, logic [7:0] pb, logic [1:0] v,
                                            logic [7:0] ds);
        t_result r;
        r.frame_end    = fe;
        r.payload_byte = pb;
        r.verdict      = v;
        r.device_state = ds;
        return r;
    endfunction

    // Place one unstuffed byte in the frame body
    task automatic absorb_body(input logic [7:0] b);
        int csum_pos;
        csum_pos = 4 + int'(payload_len);
        if (int'(fr_pos) < csum_pos) begin
            fr_sum = fr_sum + b;
            if (fr_pos == 9'd2) fr_state = b;
            if (fr_pos >= 9'd4) expected_results.push_back(make_result(1'b0, b, '0, '0));
        end else if (int'(fr_pos) == csum_pos) begin
            fr_check = b;
        end else begin
            fr_overrun = 1'b1;
        end
        if (fr_pos < POS_MAX) fr_pos = fr_pos + 9'd1;
    endtask

    // Closing flag: length first, then checksum, then device state
    task automatic close_frame();
        logic [1:0] v;
        logic [7:0] inv_sum;
        inv_sum = ~fr_sum;
        if (fr_overrun || int'(fr_pos) != 5 + int'(payload_len)) v = VERDICT_LEN_ERR;
        else if (inv_sum != fr_check)                             v = VERDICT_CSUM_ERR;
        else if (fr_state != 8'h00)                               v = VERDICT_DEV_ERR;
        else                                                      v = VERDICT_OK;
        expected_results.push_back(make_result(1'b1, '0, v, fr_state));
        fr_open = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] rx);
        bit done;
        done = 1'b0;
        if (!fr_open) begin
            if (rx == FLAG_BYTE) begin
                fr_open    = 1'b1;
                fr_esc     = 1'b0;
                fr_pos     = '0;
                fr_sum     = 8'h00;
                fr_check   = 8'h00;
                fr_state   = 8'h00;
                fr_overrun = 1'b0;
            end
        end else begin
            if (fr_esc) begin
                fr_esc = 1'b0;
                done   = 1'b1;
                case (rx)
                    ESC_CODE_FLAG: absorb_body(FLAG_BYTE);
                    ESC_CODE_ESC:  absorb_body(ESC_BYTE);
                    ESC_CODE_XON:  absorb_body(XON_BYTE);
                    ESC_CODE_XOFF: absorb_body(XOFF_BYTE);
                    default: begin
                        // unknown code: keep the escape literally, then treat rx alone
                        absorb_body(ESC_BYTE);
                        done = 1'b0;
                    end
                endcase
            end
            if (!done) begin
                if (rx == FLAG_BYTE)     close_frame();
                else if (rx == ESC_BYTE) fr_esc = 1'b1;
                else                     absorb_body(rx);
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    // Bias toward the framing and escape bytes
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) >= 25) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return XON_BYTE;
            3:       return XOFF_BYTE;
            4:       return ESC_CODE_FLAG;
            5:       return ESC_CODE_ESC;
            6:       return ESC_CODE_XON;
            7:       return ESC_CODE_XOFF;
            8:       return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic push_stuffed(input logic [7:0] b);
        case (b)
            FLAG_BYTE: begin
                rx_stream.push_back(ESC_BYTE);
                rx_stream.push_back(ESC_CODE_FLAG);
            end
            ESC_BYTE: begin
                rx_stream.push_back(ESC_BYTE);
                rx_stream.push_back(ESC_CODE_ESC);
            end
            // flow-control bytes may go either way
            XON_BYTE: begin
                if ($urandom_range(0, 1)) begin
                    rx_stream.push_back(ESC_BYTE);
                    rx_stream.push_back(ESC_CODE_XON);
                end else begin
                    rx_stream.push_back(b);
                end
            end
            XOFF_BYTE: begin
                if ($urandom_range(0, 1)) begin
                    rx_stream.push_back(ESC_BYTE);
                    rx_stream.push_back(ESC_CODE_XOFF);
                end else begin
                    rx_stream.push_back(b);
                end
            end
            default: rx_stream.push_back(b);
        endcase
    endtask

    // Mostly good frames; the rest damaged in one way
    task automatic build_frame(input int n);
        logic [7:0] body[$];
        logic [7:0] sum;
        int kind;
        int cut;
        int inj;
        sum = 8'h00;
        inj = -1;
        body.push_back(pick_byte());
        body.push_back(pick_byte());
        body.push_back(($urandom_range(0, 99) < 70) ? 8'h00 : pick_byte());
        body.push_back(8'(n));
        repeat (n) body.push_back(pick_byte());
        foreach (body[i]) sum = sum + body[i];
        body.push_back(~sum);
        kind = $urandom_range(0, 99);
        if (kind >= 55 && kind < 65) begin
            body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
        end else if (kind >= 65 && kind < 75) begin
            cut = $urandom_range(0, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
        end else if (kind >= 75 && kind < 83) begin
            repeat ($urandom_range(1, 3)) body.push_back(pick_byte());
        end else if (kind >= 83 && kind < 91) begin
            inj = $urandom_range(0, body.size() - 1);
        end
        rx_stream.push_back(FLAG_BYTE);
        foreach (body[i]) begin
            if (i == inj) rx_stream.push_back(ESC_BYTE);
            push_stuffed(body[i]);
        end
        // dangling escape right before the closing flag
        if (kind >= 91) rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(FLAG_BYTE);
    endtask

    // Line noise between frames
    task automatic push_noise();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (b == FLAG_BYTE) b = ~FLAG_BYTE;
                rx_stream.push_back(b);
            end
        end
    endtask

    // Frame long enough to saturate the byte counter
    task automatic build_runaway();
        logic [7:0] b;
        rx_stream.push_back(FLAG_BYTE);
        repeat (RUNAWAY_BYTES) begin
            b = 8'($urandom_range(0, 255));
            if (b == FLAG_BYTE) b = ~FLAG_BYTE;
            rx_stream.push_back(b);
        end
        rx_stream.push_back(FLAG_BYTE);
    endtask

    // Wait until everything is sent and every result is back, then let the pipe settle
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (rx_stream.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        #1;
    endtask

    task automatic run_phase(input logic [7:0] len, input int sidle, input int rstall,
                             input int nitems, input bit hold, input bit runaway);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = len;
        payload_len   = len;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        @(posedge i_clk);
        #1;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        if (runaway) build_runaway();
        while (rx_stream.size() < nitems) begin
            push_noise();
            build_frame(int'(len));
        end
        if (hold) hold_kick = 1'b1;
        @(posedge i_clk);
        #1;
        hold_kick = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100) $display("%0t ns: result %0d: %s", $time, result_count, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- driver

    // Offer bytes and stall the output at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= rx_stream.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long output hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_kick)           hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // ---------------------------------------------------------------- monitor

    // Predict on each accepted byte, check each accepted result
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                in_fire = 1'b1;
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got = make_result(m_tlast, m_tdata[7:0], m_tdata[9:8], m_tdata[17:10]);
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %0b, want %0b",
                                                  got.frame_end, want.frame_end));
                    if (got.payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                                  got.payload_byte, want.payload_byte));
                    if (got.verdict !== want.verdict)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  got.verdict, want.verdict));
                    if (got.device_state !== want.device_state)
                        report_mismatch($sformatf("device_state %02h, want %02h",
                                                  got.device_state, want.device_state));
                end
                result_count++;
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        #1;

        // Directed: noise, empty frame, all four escapes with a device error,
        // a clean frame, then an unknown escape and an escape before the stop
        rx_stream.push_back(8'h00);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(ESC_CODE_FLAG);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(ESC_CODE_ESC);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(ESC_CODE_XON);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(ESC_CODE_XOFF);
        rx_stream.push_back(8'hE0);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(FLAG_BYTE);
        repeat (4) rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(FLAG_BYTE);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(8'h41);
        rx_stream.push_back(ESC_BYTE);
        rx_stream.push_back(FLAG_BYTE);

        // Random phases: length, sender idle %, receiver stall %, bytes, hold-off, runaway
        run_phase(8'd3,   0,  0,  150, 1'b1, 1'b0);
        run_phase(8'd0,   83, 0,  540, 1'b0, 1'b1);
        run_phase(8'd255, 0,  83, 100, 1'b0, 1'b0);
        run_phase(8'd1,   0,  0,  100, 1'b0, 1'b0);
        run_phase(8'd7,   11, 11, 90,  1'b0, 1'b0);
        run_phase(8'd2,   83, 83, 100, 1'b0, 1'b0);
        run_phase(8'd12,  0,  0,  80,  1'b0, 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
